@@ rtl/gji_pkg.sv @@
// shared types, constants and command/status structs for the gauss-jordan inverter
// depends on nothing; imported by every rtl module of the block
package gji_pkg;

  localparam int MAX_SIZE  = 8;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_SIZE);
  localparam int CNT_W     = IDX_W + 1;
  localparam int CELL_W    = 2 * IDX_W;
  localparam int ADDR_W    = CELL_W + 1;
  localparam int SIZE_W    = 4;
  localparam int LIMIT_W   = 31;
  localparam int PADDR_W   = 3;

  localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

  // register indexes (byte address / 4)
  localparam logic REG_SIZE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_PICK, OP_DIVGO, OP_WRQ,
    OP_LDF, OP_MUL, OP_WRE, OP_OUT, OP_SING
  } dp_op_t;

  // where the row half of the port-a address comes from
  typedef enum logic [1:0] {
    RS_CTR, RS_PIV, RS_OUT
  } row_sel_t;

  typedef struct packed {
    dp_op_t           op;
    row_sel_t         rsel;
    logic             mat;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] pcol;
    logic             clr;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic             cand_ok;
    logic             div_done;
    logic             out_free;
    logic [IDX_W-1:0] prow;
  } dp_stat_t;

endpackage

@@ rtl/gji_div.sv @@
// iterative fixed-point divider, one quotient bit per cycle, saturating result
// depends on gji_pkg
module gji_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gji_pkg::DATA_W-1:0] num,
  input  logic [gji_pkg::DATA_W-1:0] den,
  output logic [gji_pkg::DATA_W-1:0] quo,
  output logic                      done
);
  import gji_pkg::*;

  localparam int DVD_W = DATA_W + FRAC_BITS;
  localparam int REM_W = DATA_W + 1;
  localparam int STP_W = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'({1'b1, {(DATA_W-1){1'b0}}});

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [STP_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] dmag_r, dmag_nxt;
  logic             neg_r, neg_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;

  logic [REM_W-1:0] num_ext, den_ext, num_mag, den_mag, rs;
  logic [REM_W:0]   trial;
  logic [DVD_W-1:0] q_neg;

  // magnitudes of the operands
  always_comb begin
    num_ext = {num[DATA_W-1], num};
    den_ext = {den[DATA_W-1], den};
    num_mag = num_ext[REM_W-1] ? (~num_ext + 1'b1) : num_ext;
    den_mag = den_ext[REM_W-1] ? (~den_ext + 1'b1) : den_ext;
  end

  // restoring step and final sign/saturation
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    rs       = {rem_r[REM_W-2:0], q_r[DVD_W-1]};
    trial    = {1'b0, rs} - {1'b0, dmag_r};
    q_neg    = ~q_r + 1'b1;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = STP_W'(DVD_W);
      q_nxt    = {num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dmag_nxt = den_mag;
      neg_nxt  = num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        if (!trial[REM_W]) begin
          rem_nxt = trial[REM_W-1:0];
          q_nxt   = {q_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rs;
          q_nxt   = {q_r[DVD_W-2:0], 1'b0};
        end
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (!neg_r) begin
          res_nxt = (q_r > POS_LIM) ? POS_LIM[DATA_W-1:0] : q_r[DATA_W-1:0];
        end else begin
          res_nxt = (q_r > NEG_LIM) ? NEG_LIM[DATA_W-1:0] : q_neg[DATA_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign quo  = res_r;
  assign done = done_r;

endmodule

@@ rtl/gji_dp.sv @@
// datapath: matrix memory, pivot bookkeeping, multiply-subtract, divider and output register
// depends on gji_pkg and gji_div
module gji_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [gji_pkg::CNT_W-1:0]   n_use,
  input  logic [gji_pkg::LIMIT_W-1:0] limit,
  input  logic [gji_pkg::DATA_W-1:0]  in_data,
  input  gji_pkg::dp_cmd_t            cmd,
  output gji_pkg::dp_stat_t           stat,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [gji_pkg::DATA_W-1:0]  out_tdata,   // inverse_value
  output logic                        out_tuser,   // singular
  output logic                        out_tlast    // last_result
);
  import gji_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int DIFF_W = SH_W + 1;
  localparam int LDC_W  = CELL_W + 1;

  // work matrix in the lower half, inverse in the upper half
  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_a_r, rd_b_r;

  logic [LDC_W-1:0]  load_cnt_r;
  logic [MAX_SIZE-1:0] used_r;
  logic [IDX_W-1:0]  p_r;
  logic [IDX_W-1:0]  prow_r [MAX_SIZE];
  logic [DATA_W-1:0] piv_r, f_r, x_r;
  logic signed [PROD_W-1:0] prod_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_sing_r, out_last_r;

  logic [IDX_W-1:0]  row_a;
  logic [CELL_W-1:0] cell_a, cell_b;
  logic [ADDR_W-1:0] addr_a, addr_b, waddr;
  logic [LDC_W-1:0]  nn;
  logic              we;
  logic [DATA_W-1:0] wdata, div_q;
  logic              div_done;
  logic [DATA_W:0]   mag_ext, mag;
  logic signed [SH_W-1:0]   sh;
  logic signed [DIFF_W-1:0] diff;
  logic [DATA_W-1:0] msub;
  logic              out_free;

  // read addresses
  always_comb begin
    case (cmd.rsel)
      RS_CTR:  row_a = cmd.row;
      RS_PIV:  row_a = p_r;
      RS_OUT:  row_a = prow_r[cmd.row];
      default: row_a = cmd.row;
    endcase
    cell_a = CELL_W'(CELL_W'(row_a) * CELL_W'(n_use) + CELL_W'(cmd.col));
    cell_b = CELL_W'(CELL_W'(p_r) * CELL_W'(n_use) + CELL_W'(cmd.col));
    addr_a = {cmd.mat, cell_a};
    addr_b = {cmd.mat, cell_b};
    nn     = LDC_W'(n_use) * LDC_W'(n_use);
  end

  // multiply-subtract with truncation toward zero and saturation
  always_comb begin
    sh   = prod_r[PROD_W-1:FRAC_BITS];
    if (prod_r[PROD_W-1] && (prod_r[FRAC_BITS-1:0] != '0)) begin
      sh = sh + SH_W'(1);
    end
    diff = DIFF_W'($signed(x_r)) - DIFF_W'(sh);
    if (diff[DIFF_W-1:DATA_W-1] == '0 || diff[DIFF_W-1:DATA_W-1] == '1) begin
      msub = diff[DATA_W-1:0];
    end else if (diff[DIFF_W-1]) begin
      msub = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      msub = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = addr_a;
    wdata = msub;
    case (cmd.op)
      OP_LOAD: begin
        we    = load_cnt_r < nn;
        waddr = {1'b0, load_cnt_r[CELL_W-1:0]};
        wdata = in_data;
      end
      OP_INIT: begin
        we    = 1'b1;
        wdata = (cmd.row == cmd.col) ? FX_ONE : '0;
      end
      OP_WRQ: begin
        we    = 1'b1;
        wdata = div_q;
      end
      OP_WRE: begin
        we    = 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // pivot candidate test
  always_comb begin
    mag_ext = {rd_a_r[DATA_W-1], rd_a_r};
    mag     = mag_ext[DATA_W] ? (~mag_ext + 1'b1) : mag_ext;
  end

  gji_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIVGO),
    .num   (rd_a_r),
    .den   (piv_r),
    .quo   (div_q),
    .done  (div_done)
  );

  assign out_free = !out_valid_r || out_tready;

  // bookkeeping and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r  <= '0;
      used_r      <= '0;
      p_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SIZE; i++) begin
        prow_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (cmd.clr) begin
            load_cnt_r <= '0;
            used_r     <= '0;
          end else if (load_cnt_r < nn) begin
            load_cnt_r <= load_cnt_r + 1'b1;
          end
        end
        OP_PICK: begin
          used_r[cmd.row]   <= 1'b1;
          p_r               <= cmd.row;
          prow_r[cmd.pcol]  <= cmd.row;
        end
        default: ;
      endcase
      if (cmd.op == OP_OUT || cmd.op == OP_SING) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.op == OP_PICK) begin
      piv_r <= rd_a_r;
    end
    if (cmd.op == OP_LDF) begin
      f_r <= rd_a_r;
    end
    if (cmd.op == OP_MUL) begin
      prod_r <= $signed(f_r) * $signed(rd_b_r);
      x_r    <= rd_a_r;
    end
    if (cmd.op == OP_OUT) begin
      out_data_r <= rd_a_r;
      out_sing_r <= 1'b0;
      out_last_r <= cmd.last;
    end else if (cmd.op == OP_SING) begin
      out_data_r <= '0;
      out_sing_r <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign stat.cand_ok  = !used_r[cmd.row] && (mag > (DATA_W+1)'(limit));
  assign stat.div_done = div_done;
  assign stat.out_free = out_free;
  assign stat.prow     = p_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sing_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/gji_ctrl.sv @@
// controller: sequences load, identity setup, pivot search, scaling, elimination and output
// depends on gji_pkg
module gji_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gji_pkg::CNT_W-1:0] n_use,
  input  logic                      in_tvalid,
  input  logic                      in_tlast,
  output logic                      in_tready,
  input  gji_pkg::dp_stat_t         stat,
  output gji_pkg::dp_cmd_t          cmd
);
  import gji_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_INIT = 16'h0002, S_SRD  = 16'h0004, S_SCHK = 16'h0008,
    S_PRD  = 16'h0010, S_PST  = 16'h0020, S_PDIV = 16'h0040, S_PWR  = 16'h0080,
    S_RSEL = 16'h0100, S_FRD  = 16'h0200, S_FLD  = 16'h0400, S_ERD  = 16'h0800,
    S_EMUL = 16'h1000, S_EWR  = 16'h2000, S_ORD  = 16'h4000, S_OLD  = 16'h8000
  } state_t;

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic             m_r, m_nxt;
  logic             sing_r, sing_nxt;
  logic [CNT_W-1:0] nm1;
  logic             row_end, k_end, col_end;

  assign nm1     = n_use - 1'b1;
  assign row_end = row_r == nm1;
  assign k_end   = k_r == nm1;
  assign col_end = CNT_W'(col_r) == nm1;

  always_comb begin
    st_nxt    = st_r;
    row_nxt   = row_r;
    k_nxt     = k_r;
    col_nxt   = col_r;
    m_nxt     = m_r;
    sing_nxt  = sing_r;
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    cmd.rsel  = RS_CTR;
    cmd.mat   = m_r;
    cmd.row   = row_r[IDX_W-1:0];
    cmd.col   = k_r[IDX_W-1:0];
    cmd.pcol  = col_r;
    cmd.clr   = in_tlast;
    cmd.last  = row_end && k_end;
    case (st_r)
      // take elements until the marked one
      S_IDLE: begin
        in_tready = !sing_r;
        if (sing_r) begin
          if (stat.out_free) begin
            cmd.op   = OP_SING;
            sing_nxt = 1'b0;
          end
        end else if (in_tvalid) begin
          cmd.op = OP_LOAD;
          if (in_tlast) begin
            row_nxt = '0;
            k_nxt   = '0;
            st_nxt  = S_INIT;
          end
        end
      end
      // inverse half set to identity
      S_INIT: begin
        cmd.mat = 1'b1;
        cmd.op  = OP_INIT;
        if (k_end) begin
          k_nxt = '0;
          if (row_end) begin
            row_nxt = '0;
            col_nxt = '0;
            m_nxt   = 1'b0;
            st_nxt  = S_SRD;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // pivot search down the current column
      S_SRD: begin
        cmd.mat = 1'b0;
        cmd.col = col_r;
        st_nxt  = S_SCHK;
      end
      S_SCHK: begin
        cmd.mat = 1'b0;
        cmd.col = col_r;
        if (stat.cand_ok) begin
          cmd.op = OP_PICK;
          k_nxt  = '0;
          m_nxt  = 1'b0;
          st_nxt = S_PRD;
        end else if (row_end) begin
          sing_nxt = 1'b1;
          st_nxt   = S_IDLE;
        end else begin
          row_nxt = row_r + 1'b1;
          st_nxt  = S_SRD;
        end
      end
      // pivot row scaling, both halves
      S_PRD: begin
        cmd.rsel = RS_PIV;
        st_nxt   = S_PST;
      end
      S_PST: begin
        cmd.rsel = RS_PIV;
        cmd.op   = OP_DIVGO;
        st_nxt   = S_PDIV;
      end
      S_PDIV: begin
        cmd.rsel = RS_PIV;
        if (stat.div_done) begin
          st_nxt = S_PWR;
        end
      end
      S_PWR: begin
        cmd.rsel = RS_PIV;
        cmd.op   = OP_WRQ;
        st_nxt   = S_PRD;
        if (k_end) begin
          k_nxt = '0;
          if (m_r) begin
            m_nxt   = 1'b0;
            row_nxt = '0;
            st_nxt  = S_RSEL;
          end else begin
            m_nxt = 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // next row to reduce, skipping the pivot row
      S_RSEL: begin
        if (row_r == n_use) begin
          row_nxt = '0;
          k_nxt   = '0;
          if (col_end) begin
            st_nxt = S_ORD;
          end else begin
            col_nxt = col_r + 1'b1;
            st_nxt  = S_SRD;
          end
        end else if (row_r[IDX_W-1:0] == stat.prow) begin
          row_nxt = row_r + 1'b1;
        end else begin
          st_nxt = S_FRD;
        end
      end
      // fetch the row factor
      S_FRD: begin
        cmd.mat = 1'b0;
        cmd.col = col_r;
        st_nxt  = S_FLD;
      end
      S_FLD: begin
        cmd.op = OP_LDF;
        k_nxt  = '0;
        m_nxt  = 1'b0;
        st_nxt = S_ERD;
      end
      // row reduction: read, multiply and write states for each element in turn
      S_ERD: begin
        st_nxt = S_EMUL;
      end
      S_EMUL: begin
        cmd.op = OP_MUL;
        st_nxt = S_EWR;
      end
      S_EWR: begin
        cmd.op = OP_WRE;
        st_nxt = S_ERD;
        if (k_end) begin
          k_nxt = '0;
          if (m_r) begin
            m_nxt   = 1'b0;
            row_nxt = row_r + 1'b1;
            st_nxt  = S_RSEL;
          end else begin
            m_nxt = 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // emit the inverse in column pivot order
      S_ORD: begin
        cmd.mat  = 1'b1;
        cmd.rsel = RS_OUT;
        st_nxt   = S_OLD;
      end
      S_OLD: begin
        cmd.mat  = 1'b1;
        cmd.rsel = RS_OUT;
        if (stat.out_free) begin
          cmd.op = OP_OUT;
          st_nxt = S_ORD;
          if (k_end) begin
            k_nxt = '0;
            if (row_end) begin
              st_nxt = S_IDLE;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      row_r  <= '0;
      k_r    <= '0;
      col_r  <= '0;
      m_r    <= 1'b0;
      sing_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      row_r  <= row_nxt;
      k_r    <= k_nxt;
      col_r  <= col_nxt;
      m_r    <= m_nxt;
      sing_r <= sing_nxt;
    end
  end

endmodule

@@ rtl/gauss_jordan_matrix_inverse.sv @@
// top level of the gauss-jordan matrix inverter: config registers, controller and datapath
// depends on gji_pkg, gji_ctrl, gji_dp
//
// usage
//   in_*   : matrix elements, signed Q16.16, row-major; in_tlast on the final element
//            starts the inversion. elements beyond n*n are dropped.
//   out_*  : inverse elements row-major, n*n transfers, tlast on the final one.
//            a singular matrix gives one transfer with tuser set and zero data.
//   cfg_*  : register 0 matrix size (4 bits, 0 acts as 1, above 8 acts as 8),
//            register 1 pivot magnitude limit (31 bits). write only while idle.
// timing
//   one element loads per cycle while idle with no singular result waiting. after the
//   marked element the block is busy with the inversion, its run time set by the
//   48-step divider used for pivot row scaling and the shared multiply-subtract unit,
//   then reads and loads the results one at a time. in_tready stays low until the last result
//   has been handed to the output register.
// reset
//   rst_n clears the controller, load count, pivot flags and output valid; size returns
//   to 8 and the limit to 1. a stalled receiver holds the output register and pauses
//   the controller; nothing is dropped.
module gauss_jordan_matrix_inverse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [gji_pkg::DATA_W-1:0]   in_tdata,    // element_value
  input  logic                         in_tlast,    // last_element
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [gji_pkg::DATA_W-1:0]   out_tdata,   // inverse_value
  output logic                         out_tuser,   // singular
  output logic                         out_tlast,   // last_result
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [gji_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import gji_pkg::*;

  logic [SIZE_W-1:0]  size_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   n_use;
  logic               cfg_wr;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_W'(MAX_SIZE);
      limit_r <= LIMIT_W'(1);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SIZE:  size_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_LIMIT: limit_r <= cfg_pwdata[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (cfg_paddr[2])
      REG_SIZE:  cfg_prdata = 32'(size_r);
      REG_LIMIT: cfg_prdata = 32'(limit_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // size in use, clamped to 1..MAX_SIZE
  always_comb begin
    if (size_r == '0) begin
      n_use = CNT_W'(1);
    end else if (size_r > SIZE_W'(MAX_SIZE)) begin
      n_use = CNT_W'(MAX_SIZE);
    end else begin
      n_use = CNT_W'(size_r);
    end
  end

  gji_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_use     (n_use),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gji_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_use      (n_use),
    .limit      (limit_r),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/gji_chk.sv @@
// port-level checker for the gauss-jordan inverter, bound to the top level
// depends on gji_pkg
module gji_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [gji_pkg::DATA_W-1:0] out_tdata,
  input logic                       out_tuser,
  input logic                       out_tlast
);
  import gji_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // a singular flag comes alone, zero and last
  a_sing_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0 && out_tlast)
    else $error("malformed singular result");

  // the input closes once the marked element is taken
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input open right after final element");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind gauss_jordan_matrix_inverse gji_chk u_gji_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ tb/sv/gauss_jordan_matrix_inverse_tb.sv @@
// testbench for the gauss-jordan matrix inverter: streams matrices, predicts the inverse
// depends on gji_pkg and the gauss_jordan_matrix_inverse rtl; needs nothing else
`timescale 1ns / 100ps

module gauss_jordan_matrix_inverse_tb;
  import gji_pkg::*;

  localparam int  CELLS       = MAX_SIZE * MAX_SIZE;
  localparam int  TARGET      = 310;
  localparam int  QUIET_AFTER = 270;
  localparam int  CYCLE_LIMIT = 20000000;
  localparam int  ONE         = 1 << FRAC_BITS;
  localparam int  INT_MIN     = 32'sh8000_0000;
  localparam int  INT_MAX     = 32'sh7fff_ffff;

  // kinds of random matrix
  typedef enum int {MK_DOMINANT, MK_NOISE, MK_DEPENDENT, MK_SHORT, MK_LONG} mat_kind_t;

  typedef struct {
    int   value;
    logic singular;
    logic last;
  } inv_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;    // element_value
  logic                in_tlast;    // last_element
  logic                out_tvalid;
  logic                out_tready;
  logic [DATA_W-1:0]   out_tdata;   // inverse_value
  logic                out_tuser;   // singular
  logic                out_tlast;   // last_result
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [PADDR_W-1:0]  cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  gauss_jordan_matrix_inverse dut (.*);

  // predictor state
  int          work_cells [CELLS];
  int          inv_cells  [CELLS];
  int          piv_of_col [MAX_SIZE];
  int          load_cnt;
  logic [3:0]  size_reg;
  logic [30:0] limit_reg;
  int          cells_written;   // highest flat index written since reset, plus one
  inv_result_t expected_q[$];

  int  errors;
  int  sent;
  int  cycles;
  bit  quiet;
  int  in_gap;
  int  out_stall;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int sat32(longint v);
    if (v > longint'(INT_MAX)) return INT_MAX;
    if (v < longint'(INT_MIN)) return INT_MIN;
    return int'(v);
  endfunction

  function automatic int size_now();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_SIZE) return MAX_SIZE;
    return int'(size_reg);
  endfunction

  // gauss-jordan on the shadow copy; returns 0 when a column has no usable pivot
  function automatic bit eliminate(int n);
    int     p;
    int     piv;
    int     f;
    bit     found;
    bit     used [MAX_SIZE];
    for (int i = 0; i < CELLS; i++) inv_cells[i] = 0;
    for (int r = 0; r < n; r++) begin
      inv_cells[r*n+r] = ONE;
      used[r] = 1'b0;
    end
    for (int c = 0; c < n; c++) begin
      found = 1'b0;
      p = 0;
      for (int r = 0; r < n && !found; r++) begin
        longint m;
        m = longint'(work_cells[r*n+c]);
        if (m < 0) m = -m;
        if (!used[r] && m > longint'(limit_reg)) begin
          p = r;
          found = 1'b1;
        end
      end
      if (!found) return 1'b0;
      used[p] = 1'b1;
      piv_of_col[c] = p;
      piv = work_cells[p*n+c];
      for (int k = 0; k < n; k++) begin
        work_cells[p*n+k] = sat32((longint'(work_cells[p*n+k]) * ONE) / longint'(piv));
        inv_cells[p*n+k]  = sat32((longint'(inv_cells[p*n+k]) * ONE) / longint'(piv));
      end
      for (int r = 0; r < n; r++) begin
        if (r != p) begin
          f = work_cells[r*n+c];
          for (int k = 0; k < n; k++) begin
            work_cells[r*n+k] = sat32(longint'(work_cells[r*n+k]) -
              (longint'(f) * longint'(work_cells[p*n+k])) / ONE);
            inv_cells[r*n+k] = sat32(longint'(inv_cells[r*n+k]) -
              (longint'(f) * longint'(inv_cells[p*n+k])) / ONE);
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // update the shadow state for one accepted element and queue the results it causes
  task automatic predict_element(int value, logic mark);
    int          n;
    inv_result_t res;
    n = size_now();
    if (load_cnt < n*n) begin
      work_cells[load_cnt] = value;
      load_cnt++;
      if (load_cnt > cells_written) cells_written = load_cnt;
    end
    if (mark) begin
      load_cnt = 0;
      if (!eliminate(n)) begin
        res.value = 0;
        res.singular = 1'b1;
        res.last = 1'b1;
        expected_q.push_back(res);
      end else begin
        for (int r = 0; r < n; r++)
          for (int j = 0; j < n; j++) begin
            res.value = inv_cells[(piv_of_col[r] % n)*n + j];
            res.singular = 1'b0;
            res.last = (r == n-1 && j == n-1);
            expected_q.push_back(res);
          end
      end
    end
  endtask

  // one element transfer, at times with a random gap in front
  task automatic send_element(int value, logic mark);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= mark;
    do @(posedge clk); while (!in_tready);
    predict_element(value, mark);
    sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // apb write: setup then access, only while nothing is in flight
  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == 3'(4*REG_SIZE)) size_reg = data[3:0];
    else if (addr == 3'(4*REG_LIMIT)) limit_reg = data[30:0];
  endtask

  task automatic set_size(int n);
    reg_write(3'(4*REG_SIZE), 32'(n));
  endtask

  task automatic set_limit(int lim);
    reg_write(3'(4*REG_LIMIT), 32'(lim));
  endtask

  // element of a well-conditioned matrix
  function automatic int dominant_cell(int n, int r, int c);
    int v;
    if (r == c) begin
      v = n * ONE + int'($urandom_range(ONE, 4*ONE));
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = int'($urandom_range(0, 2*ONE)) - ONE;
    end
    return v;
  endfunction

  // build and stream one matrix at the current size
  task automatic send_matrix(mat_kind_t kind);
    int n;
    int cnt;
    int vals[$];
    n = size_now();
    cnt = n*n;
    if (kind == MK_SHORT && cells_written >= n*n && n > 1) cnt = $urandom_range(1, n*n-1);
    if (kind == MK_LONG) cnt = n*n + $urandom_range(1, 3);
    for (int i = 0; i < cnt; i++) begin
      int r;
      int c;
      r = (i / n) % n;
      c = i % n;
      case (kind)
        MK_NOISE:     vals.push_back(int'($urandom));
        MK_DEPENDENT: vals.push_back((r == 1 && n > 1) ? vals[c] : dominant_cell(n, r, c));
        default:      vals.push_back(dominant_cell(n, r, c));
      endcase
    end
    foreach (vals[i]) send_element(vals[i], i == cnt-1);
  endtask

  // 1x1 extremes, singular scalars and saturating quotients
  task automatic test_scalar_extremes();
    set_size(1);
    send_element(INT_MIN, 1'b1);
    send_element(INT_MAX, 1'b1);
    send_element(ONE, 1'b1);
    send_element(0, 1'b1);
    send_element(-1, 1'b1);
    set_limit(0);
    send_element(1, 1'b1);
    send_element(-1, 1'b1);
  endtask

  // pivot limit at its top: only the most negative value passes
  task automatic test_limit_max();
    set_limit(INT_MAX);
    send_element(INT_MIN, 1'b1);
    send_element(INT_MAX, 1'b1);
    set_limit(1);
  endtask

  // size 0 acts as 1, size above the maximum acts as the maximum
  task automatic test_size_clamp();
    set_size(0);
    send_element(3*ONE, 1'b1);
    set_size(15);
    send_matrix(MK_DOMINANT);
  endtask

  // extra elements dropped, too few reuse old cells, size change while loading
  task automatic test_element_count();
    set_size(2);
    send_matrix(MK_LONG);
    send_element(2*ONE, 1'b0);
    send_element(-ONE, 1'b1);
    set_size(3);
    for (int i = 0; i < 4; i++) send_element(dominant_cell(3, i/3, i%3), 1'b0);
    set_size(2);
    send_element(ONE, 1'b1);
  endtask

  // singularity found in a later column
  task automatic test_singular_late();
    set_size(3);
    send_matrix(MK_DEPENDENT);
  endtask

  // random phases, mostly small sizes, last stretch without idling
  task automatic test_random();
    int kindsel;
    while (sent < TARGET) begin
      if (sent >= QUIET_AFTER) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 15) == 0) set_size($urandom_range(0, 15));
        else set_size($urandom_range(1, 4));
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: set_limit(0);
          1: set_limit(1);
          2: set_limit($urandom_range(0, 4*ONE));
          default: set_limit(ONE / 2);
        endcase
      end
      kindsel = $urandom_range(0, 19);
      if (kindsel < 13) send_matrix(MK_DOMINANT);
      else if (kindsel < 15) send_matrix(MK_NOISE);
      else if (kindsel < 17) send_matrix(MK_DEPENDENT);
      else if (kindsel < 18) send_matrix(MK_SHORT);
      else send_matrix(MK_LONG);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result data=%h singular=%b last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        inv_result_t e;
        e = expected_q.pop_front();
        if (out_tdata !== e.value) begin
          $display("%0t: inverse_value expected %h actual %h", $time, e.value, out_tdata);
          errors++;
        end
        if (out_tuser !== e.singular) begin
          $display("%0t: singular expected %b actual %b", $time, e.singular, out_tuser);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: last_result expected %b actual %b", $time, e.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      out_stall  <= 0;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall  <= out_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      out_stall  <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    sent = 0;
    cycles = 0;
    quiet = 1'b0;
    load_cnt = 0;
    cells_written = 0;
    size_reg = 4'd8;
    limit_reg = 31'd1;
    foreach (work_cells[i]) work_cells[i] = 0;
    foreach (piv_of_col[i]) piv_of_col[i] = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b1;
    out_stall = 0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_size_clamp();
    test_scalar_extremes();
    test_limit_max();
    test_element_count();
    test_singular_late();
    test_random();

    quiet = 1'b1;
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
